// ----- src/ksle_pkg.sv -----
// shared types, constants and key map of the keypad scan line editor
package ksle_pkg;

  localparam int ROW_COUNT = 4;
  localparam int COL_COUNT = 3;
  localparam int KEY_TOTAL = ROW_COUNT * COL_COUNT;

  localparam int LINE_DEPTH_DEFAULT  = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd5;
  localparam logic [7:0] COUNT_MAX      = 8'd255;

  localparam logic [7:0] CHAR_COMMIT = 8'h23;  // '#'
  localparam logic [7:0] CHAR_DELETE = 8'h2A;  // '*'

  // key characters in scan order, index col*ROW_COUNT+row
  localparam logic [7:0] KEY_CHARS [KEY_TOTAL] = '{
    8'h33, 8'h36, 8'h39, 8'h23,   // column 0: '3' '6' '9' '#'
    8'h32, 8'h35, 8'h38, 8'h30,   // column 1: '2' '5' '8' '0'
    8'h31, 8'h34, 8'h37, 8'h2A    // column 2: '1' '4' '7' '*'
  };

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_DELETE,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND,
    BK_TERM
  } bk_state_t;

endpackage

// ----- src/ksle_front.sv -----
// scan front: debounces the twelve keys, finds the first new press and classifies it
module ksle_front
  import ksle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KEY_TOTAL-1:0] key_closed,
  input  queue_status_t        q_status,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [7:0]           debounce_ticks;
  logic [KEY_TOTAL-1:0] stable;
  logic [7:0]           count [KEY_TOTAL];

  logic [7:0]           need;
  logic [KEY_TOTAL-1:0] stable_next;
  logic [7:0]           count_next [KEY_TOTAL];
  logic [KEY_TOTAL-1:0] rise;
  logic [KEY_TOTAL-1:0] blocked;
  logic [KEY_TOTAL-1:0] first;
  logic [7:0]           bumped [KEY_TOTAL];
  logic [7:0]           key_ch;
  logic                 accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign need     = (debounce_ticks == 8'd0) ? 8'd1 : debounce_ticks;

  // per-key debounce step, all keys side by side
  always_comb begin
    for (int i = 0; i < KEY_TOTAL; i++) begin
      bumped[i] = (count[i] == COUNT_MAX) ? COUNT_MAX : count[i] + 8'd1;
      if (key_closed[i] == stable[i]) begin
        stable_next[i] = stable[i];
        count_next[i]  = 8'd0;
      end else if (bumped[i] >= need) begin
        stable_next[i] = key_closed[i];
        count_next[i]  = 8'd0;
      end else begin
        stable_next[i] = stable[i];
        count_next[i]  = bumped[i];
      end
      rise[i] = stable_next[i] && !stable[i];
    end
  end

  // keys after the first new press are not sampled this tick
  always_comb begin
    key_ch = 8'd0;
    for (int i = 0; i < KEY_TOTAL; i++) begin
      blocked[i] = |(rise & ((KEY_TOTAL'(1) << i) - KEY_TOTAL'(1)));
      first[i]   = rise[i] && !blocked[i];
      key_ch     = key_ch | (first[i] ? KEY_CHARS[i] : 8'd0);
    end
  end

  always_comb begin
    push        = accept && (|rise);
    push_cmd.ch = key_ch;
    unique case (key_ch)
      CHAR_COMMIT: push_cmd.op = OP_COMMIT;
      CHAR_DELETE: push_cmd.op = OP_DELETE;
      default:     push_cmd.op = OP_APPEND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      stable         <= '0;
      for (int i = 0; i < KEY_TOTAL; i++) begin
        count[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        debounce_ticks <= cfg_data;
      end
      if (accept) begin
        for (int i = 0; i < KEY_TOTAL; i++) begin
          if (!blocked[i]) begin
            stable[i] <= stable_next[i];
            count[i]  <= count_next[i];
          end
        end
      end
    end
  end

endmodule

// ----- src/ksle_queue.sv -----
// short command queue between scan front and line editor back
module ksle_queue
  import ksle_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head         = slots[rd_ptr];
  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/ksle_back.sv -----
// line editor back: line memory, edit commands and line output register
module ksle_back
  import ksle_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
)(
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          head,
  input  queue_status_t q_status,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_last,
  output logic [4:0]    line_count
);

  localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [7:0]       line_mem [LINE_DEPTH];
  logic [7:0]       rd_data;

  bk_state_t        state, state_next;
  logic [LEN_W-1:0] line_len, line_len_next;
  logic [LEN_W-1:0] commit_len, commit_len_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic             out_valid_next;
  logic [7:0]       out_char_next;
  logic             out_last_next;
  logic [4:0]       line_count_next;
  logic             mem_we;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[line_len[ADDR_W-1:0]] <= head.ch;
    end
    rd_data <= line_mem[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      line_len  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      line_len  <= line_len_next;
      out_valid <= out_valid_next;
    end
    commit_len <= commit_len_next;
    idx        <= idx_next;
    out_char   <= out_char_next;
    out_last   <= out_last_next;
    line_count <= line_count_next;
  end

  always_comb begin
    state_next      = state;
    line_len_next   = line_len;
    commit_len_next = commit_len;
    idx_next        = idx;
    out_valid_next  = out_valid && !out_ready;
    out_char_next   = out_char;
    out_last_next   = out_last;
    line_count_next = line_count;
    pop             = 1'b0;
    mem_we          = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          unique case (head.op)
            OP_APPEND: begin
              if (line_len < LEN_W'(LINE_DEPTH)) begin
                mem_we        = 1'b1;
                line_len_next = line_len + LEN_W'(1);
              end
            end
            OP_DELETE: begin
              if (line_len != '0) begin
                line_len_next = line_len - LEN_W'(1);
              end
            end
            OP_COMMIT: begin
              commit_len_next = line_len;
              idx_next        = '0;
              state_next      = (line_len == '0) ? BK_TERM : BK_READ;
            end
            default: begin
            end
          endcase
        end
      end
      BK_READ: begin
        state_next = BK_SEND;
      end
      BK_SEND: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_char_next   = rd_data;
          out_last_next   = 1'b0;
          line_count_next = 5'(commit_len);
          idx_next        = idx + LEN_W'(1);
          state_next      = (idx + LEN_W'(1) == commit_len) ? BK_TERM : BK_READ;
        end
      end
      BK_TERM: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_char_next   = 8'd0;
          out_last_next   = 1'b1;
          line_count_next = 5'(commit_len);
          line_len_next   = '0;
          state_next      = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

// ----- src/keypad_scan_line_editor.sv -----
// top level of the keypad scan line editor
//
// each transfer on the input channel is one scan tick with the raw contacts of
// all twelve keys of a 4x3 keypad (bit col*4+row, 1 = closed); keys are scanned
// in that bit order through per-key counter debouncers, and the first key that
// newly settles as pressed ends the scan for that tick. its character drives a
// line editor: '*' deletes, '#' sends the stored line as one output transfer
// per character followed by a zero terminator with out_last set, any other key
// appends while the line has room. line_count on every output transfer is the
// committed line length, masked to 5 bits. ticks keep being taken while the
// four-entry command queue has room. the editor pops one queued command at a
// time while idle; a commit of n characters runs through the pop, then per
// character a registered line memory read and a load of the output register,
// then the terminator, each load waiting while an output transfer is untaken.
// debounce_ticks is written through cfg_we/cfg_data (reset value 5, zero acts
// as one) and must only change while the block is idle.
module keypad_scan_line_editor
  import ksle_pkg::*;
#(
  parameter int LINE_DEPTH  = LINE_DEPTH_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
  input  logic        clk,
  input  logic        rst,
  // debounce_ticks register write
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  // scan tick channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] key_closed,
  // committed line channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last,
  output logic [4:0]  line_count
);

  queue_status_t q_status;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;

  // front: debounce and classify one tick per transfer
  ksle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_closed (key_closed),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // decouples the scan from line output stalls
  ksle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // back: edits the line and streams it out on commit
  ksle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .out_last   (out_last),
    .line_count (line_count)
  );

endmodule

// ----- src/ksle_checker.sv -----
// port-level checks of the keypad scan line editor and their binding
module ksle_checker
  import ksle_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic [4:0] line_count
);

  // a stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last)
      && $stable(line_count))
    else $error("output payload changed while stalled");

  // the terminator carries a zero character
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_char == 8'd0)
    else $error("terminator with nonzero character");

  // line characters are never zero and never an edit key
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_char != 8'd0 && out_char != CHAR_COMMIT
      && out_char != CHAR_DELETE)
    else $error("illegal line character");

  // the whole line reports one length
  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> !out_valid || line_count == $past(line_count))
    else $error("line_count changed inside a line");

endmodule

bind keypad_scan_line_editor ksle_checker u_ksle_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_char   (out_char),
  .out_last   (out_last),
  .line_count (line_count)
);
